>>> src/cau_pkg.sv
package cau_pkg;

   localparam int MAX_LEVELS = 64;
   localparam int IDX_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int CNT_W      = $clog2(MAX_LEVELS + 1);
   localparam int PRICE_W    = 32;
   localparam int QTY_W      = 32;
   localparam int VOL_W      = 38;
   localparam int DIST_W     = 33;
   localparam int REQ_DATA_W = 96;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 2;
   localparam int RSP_PAD_W  = RSP_DATA_W - VOL_W - PRICE_W;

   localparam logic [VOL_W-1:0] VOL_MAX = '1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEVELS);

   typedef enum logic [0:0] {
      CMD_LOAD    = 1'b0,
      CMD_UNCROSS = 1'b1
   } cmd_type;

   typedef enum logic [0:0] {
      SIDE_BUY  = 1'b0,
      SIDE_SELL = 1'b1
   } side_type;

   typedef enum logic [1:0] {
      PR_NONE = 2'd0,
      PR_BUY  = 2'd1,
      PR_SELL = 2'd2
   } pressure_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_SUMB,
      ST_SUMS,
      ST_EVAL,
      ST_DECIDE,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic signed [PRICE_W-1:0] price;
      logic [QTY_W-1:0]          qty;
   } level_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      level_type        wdata;
      logic [IDX_W-1:0] raddr;
   } mem_port_type;

endpackage

>>> src/cau_level_mem.sv
module cau_level_mem
   import cau_pkg::*;
(
   input  logic         clock,
   input  mem_port_type port,
   output level_type    rdata
);

   level_type mem [MAX_LEVELS];
   level_type rd_ff;

   always_ff @(posedge clock) begin
      if (port.we) begin
         mem[port.waddr] <= port.wdata;
      end
      rd_ff <= mem[port.raddr];
   end

   assign rdata = rd_ff;

endmodule

>>> src/call_auction_uncross.sv
// Load item: no result, the sequencer stays idle; req_tready is high whenever the sequencer is idle.
// Uncross item: buy prices high to low, then sell prices low to high, each distinct price once
//   per side, go through find, buy sum, sell sum, evaluate and decide; the result is registered
//   in finish once a previous result is taken, and the next item is accepted from then on.
// One level read and one shared compare / saturating add per cycle; one uncross at a time.
// Reset (synchronous, active high) empties the book, drops the dropped flag and the result.
module call_auction_uncross
   import cau_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // level_price, level_quantity, reference_price
   input  logic [REQ_USER_W-1:0] req_tuser,  // command, level_side
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // clear_price, matched_quantity, zero pad
   output logic [RSP_USER_W-1:0] rsp_tuser   // found, overflow
);

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          buy_cnt_ff, buy_cnt_in;
   logic [CNT_W-1:0]          sell_cnt_ff, sell_cnt_in;
   logic                      dropped_ff, dropped_in;
   logic signed [PRICE_W-1:0] ref_ff, ref_in;
   side_type                  side_ff, side_in;
   logic signed [PRICE_W-1:0] bound_ff, bound_in;
   logic                      have_bound_ff, have_bound_in;
   logic                      got_ff, got_in;
   logic signed [PRICE_W-1:0] next_ff, next_in;
   logic signed [PRICE_W-1:0] cand_ff, cand_in;
   logic [VOL_W-1:0]          dem_ff, dem_in;
   logic [VOL_W-1:0]          sup_ff, sup_in;
   logic [CNT_W-1:0]          scan_idx_ff, scan_idx_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic [VOL_W-1:0]          ev_vol_ff, ev_vol_in;
   logic [VOL_W-1:0]          ev_sur_ff, ev_sur_in;
   pressure_type              ev_pr_ff, ev_pr_in;
   logic [DIST_W-1:0]         ev_d_ff, ev_d_in;
   logic signed [PRICE_W-1:0] best_price_ff, best_price_in;
   logic [VOL_W-1:0]          best_vol_ff, best_vol_in;
   logic [VOL_W-1:0]          best_sur_ff, best_sur_in;
   pressure_type              best_pr_ff, best_pr_in;
   logic [DIST_W-1:0]         best_d_ff, best_d_in;
   logic                      have_best_ff, have_best_in;
   logic                      rsp_vld_ff, rsp_vld_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic signed [PRICE_W-1:0] rsp_price_ff, rsp_price_in;
   logic [VOL_W-1:0]          rsp_qty_ff, rsp_qty_in;
   logic                      rsp_ovf_ff, rsp_ovf_in;

   cmd_type                   req_cmd;
   side_type                  req_side;
   logic signed [PRICE_W-1:0] req_price;
   logic [QTY_W-1:0]          req_qty;
   logic signed [PRICE_W-1:0] req_ref;
   logic                      req_acc;
   mem_port_type              buy_port, sell_port;
   level_type                 buy_rd, sell_rd, rd_lvl;
   logic [CNT_W-1:0]          scan_cnt;
   logic                      scanning, issue, scan_done;
   logic                      down, skip, better, hit;
   logic [VOL_W-1:0]          acc_op;
   logic [VOL_W:0]            add_sum;
   logic [VOL_W-1:0]          add_sat;
   logic signed [DIST_W-1:0]  diff;
   logic                      upd;

   function automatic logic preferred(
      input logic signed [PRICE_W-1:0] p,
      input logic [VOL_W-1:0]          vol,
      input logic [VOL_W-1:0]          sur,
      input pressure_type              pr,
      input logic [DIST_W-1:0]         d,
      input logic signed [PRICE_W-1:0] bp,
      input logic [VOL_W-1:0]          bvol,
      input logic [VOL_W-1:0]          bsur,
      input pressure_type              bpr,
      input logic [DIST_W-1:0]         bd
   );
      logic res;
      if (vol != bvol) begin
         res = vol > bvol;
      end else if (sur != bsur) begin
         res = sur < bsur;
      end else if (pr == bpr && pr == PR_BUY) begin
         res = p > bp;
      end else if (pr == bpr && pr == PR_SELL) begin
         res = p < bp;
      end else if (d != bd) begin
         res = d < bd;
      end else begin
         res = p > bp;
      end
      return res;
   endfunction

   assign req_cmd   = cmd_type'(req_tuser[0]);
   assign req_side  = side_type'(req_tuser[1]);
   assign req_price = req_tdata[31:0];
   assign req_qty   = req_tdata[63:32];
   assign req_ref   = req_tdata[95:64];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      buy_port.we        = req_acc && req_cmd == CMD_LOAD && req_side == SIDE_BUY
                           && buy_cnt_ff < CNT_MAX;
      buy_port.waddr     = buy_cnt_ff[IDX_W-1:0];
      buy_port.wdata     = '{price: req_price, qty: req_qty};
      buy_port.raddr     = scan_idx_ff[IDX_W-1:0];
      sell_port.we       = req_acc && req_cmd == CMD_LOAD && req_side == SIDE_SELL
                           && sell_cnt_ff < CNT_MAX;
      sell_port.waddr    = sell_cnt_ff[IDX_W-1:0];
      sell_port.wdata    = '{price: req_price, qty: req_qty};
      sell_port.raddr    = scan_idx_ff[IDX_W-1:0];
   end

   cau_level_mem u_buy_mem (
      .clock (clock),
      .port  (buy_port),
      .rdata (buy_rd)
   );

   cau_level_mem u_sell_mem (
      .clock (clock),
      .port  (sell_port),
      .rdata (sell_rd)
   );

   // scan sequencing and the shared compare / add unit
   always_comb begin
      case (state_ff)
         ST_FIND: scan_cnt = (side_ff == SIDE_BUY) ? buy_cnt_ff : sell_cnt_ff;
         ST_SUMB: scan_cnt = buy_cnt_ff;
         ST_SUMS: scan_cnt = sell_cnt_ff;
         default: scan_cnt = '0;
      endcase
      scanning  = state_ff == ST_FIND || state_ff == ST_SUMB || state_ff == ST_SUMS;
      issue     = scanning && scan_idx_ff < scan_cnt;
      scan_done = scanning && !issue && !rd_vld_ff;
      rd_lvl    = (state_ff == ST_SUMS || (state_ff == ST_FIND && side_ff == SIDE_SELL))
                  ? sell_rd : buy_rd;
      down      = side_ff == SIDE_BUY;
      skip      = have_bound_ff && (down ? rd_lvl.price >= bound_ff
                                         : rd_lvl.price <= bound_ff);
      better    = !got_ff || (down ? rd_lvl.price > next_ff : rd_lvl.price < next_ff);
      hit       = (state_ff == ST_SUMB) ? rd_lvl.price >= cand_ff : rd_lvl.price <= cand_ff;
      acc_op    = (state_ff == ST_SUMS) ? sup_ff : dem_ff;
      add_sum   = {1'b0, acc_op} + (VOL_W + 1)'(rd_lvl.qty);
      add_sat   = add_sum[VOL_W] ? VOL_MAX : add_sum[VOL_W-1:0];
      diff      = DIST_W'(cand_ff) - DIST_W'(ref_ff);
      upd       = ev_vol_ff != '0 && (!have_best_ff ||
                  preferred(cand_ff, ev_vol_ff, ev_sur_ff, ev_pr_ff, ev_d_ff,
                            best_price_ff, best_vol_ff, best_sur_ff, best_pr_ff,
                            best_d_ff));
   end

   always_comb begin
      state_in      = state_ff;
      buy_cnt_in    = buy_cnt_ff;
      sell_cnt_in   = sell_cnt_ff;
      dropped_in    = dropped_ff;
      ref_in        = ref_ff;
      side_in       = side_ff;
      bound_in      = bound_ff;
      have_bound_in = have_bound_ff;
      got_in        = got_ff;
      next_in       = next_ff;
      cand_in       = cand_ff;
      dem_in        = dem_ff;
      sup_in        = sup_ff;
      ev_vol_in     = ev_vol_ff;
      ev_sur_in     = ev_sur_ff;
      ev_pr_in      = ev_pr_ff;
      ev_d_in       = ev_d_ff;
      best_price_in = best_price_ff;
      best_vol_in   = best_vol_ff;
      best_sur_in   = best_sur_ff;
      best_pr_in    = best_pr_ff;
      best_d_in     = best_d_ff;
      have_best_in  = have_best_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_price_in  = rsp_price_ff;
      rsp_qty_in    = rsp_qty_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rd_vld_in     = issue;
      if (issue) begin
         scan_idx_in = scan_idx_ff + CNT_W'(1);
      end else if (scanning && !scan_done) begin
         scan_idx_in = scan_idx_ff;
      end else begin
         scan_idx_in = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_cmd == CMD_LOAD) begin
                  if (req_side == SIDE_BUY) begin
                     if (buy_cnt_ff < CNT_MAX) begin
                        buy_cnt_in = buy_cnt_ff + CNT_W'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end else begin
                     if (sell_cnt_ff < CNT_MAX) begin
                        sell_cnt_in = sell_cnt_ff + CNT_W'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
               end else begin
                  ref_in        = req_ref;
                  have_best_in  = 1'b0;
                  best_price_in = '0;
                  best_vol_in   = '0;
                  best_sur_in   = '0;
                  best_pr_in    = PR_NONE;
                  side_in       = SIDE_BUY;
                  have_bound_in = 1'b0;
                  got_in        = 1'b0;
                  state_in      = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            if (rd_vld_ff && !skip && better) begin
               got_in  = 1'b1;
               next_in = rd_lvl.price;
            end
            if (scan_done) begin
               got_in = 1'b0;
               if (got_ff) begin
                  cand_in       = next_ff;
                  bound_in      = next_ff;
                  have_bound_in = 1'b1;
                  dem_in        = '0;
                  sup_in        = '0;
                  state_in      = ST_SUMB;
               end else if (side_ff == SIDE_BUY) begin
                  side_in       = SIDE_SELL;
                  have_bound_in = 1'b0;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_SUMB: begin
            if (rd_vld_ff && hit) begin
               dem_in = add_sat;
            end
            if (scan_done) begin
               state_in = ST_SUMS;
            end
         end
         ST_SUMS: begin
            if (rd_vld_ff && hit) begin
               sup_in = add_sat;
            end
            if (scan_done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (dem_ff < sup_ff) begin
               ev_vol_in = dem_ff;
               ev_sur_in = sup_ff - dem_ff;
               ev_pr_in  = PR_SELL;
            end else begin
               ev_vol_in = sup_ff;
               ev_sur_in = dem_ff - sup_ff;
               ev_pr_in  = (dem_ff == sup_ff) ? PR_NONE : PR_BUY;
            end
            ev_d_in  = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (upd) begin
               have_best_in  = 1'b1;
               best_price_in = cand_ff;
               best_vol_in   = ev_vol_ff;
               best_sur_in   = ev_sur_ff;
               best_pr_in    = ev_pr_ff;
               best_d_in     = ev_d_ff;
            end
            state_in = ST_FIND;
         end
         ST_FIN: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in   = 1'b1;
               rsp_found_in = have_best_ff;
               rsp_price_in = have_best_ff ? best_price_ff : '0;
               rsp_qty_in   = have_best_ff ? best_vol_ff : '0;
               rsp_ovf_in   = dropped_ff;
               buy_cnt_in   = '0;
               sell_cnt_in  = '0;
               dropped_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         buy_cnt_ff   <= '0;
         sell_cnt_ff  <= '0;
         dropped_ff   <= 1'b0;
         scan_idx_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         have_best_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         buy_cnt_ff   <= buy_cnt_in;
         sell_cnt_ff  <= sell_cnt_in;
         dropped_ff   <= dropped_in;
         scan_idx_ff  <= scan_idx_in;
         rd_vld_ff    <= rd_vld_in;
         have_best_ff <= have_best_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ref_ff        <= ref_in;
      side_ff       <= side_in;
      bound_ff      <= bound_in;
      have_bound_ff <= have_bound_in;
      got_ff        <= got_in;
      next_ff       <= next_in;
      cand_ff       <= cand_in;
      dem_ff        <= dem_in;
      sup_ff        <= sup_in;
      ev_vol_ff     <= ev_vol_in;
      ev_sur_ff     <= ev_sur_in;
      ev_pr_ff      <= ev_pr_in;
      ev_d_ff       <= ev_d_in;
      best_price_ff <= best_price_in;
      best_vol_ff   <= best_vol_in;
      best_sur_ff   <= best_sur_in;
      best_pr_ff    <= best_pr_in;
      best_d_ff     <= best_d_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_price_ff  <= rsp_price_in;
      rsp_qty_ff    <= rsp_qty_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_qty_ff, rsp_price_ff};
   assign rsp_tuser  = {rsp_ovf_ff, rsp_found_ff};

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      buy_cnt_ff <= CNT_MAX && sell_cnt_ff <= CNT_MAX)
      else $error("level count beyond capacity");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == ST_FIN))
      else $error("result raised outside finish");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_found_ff |-> rsp_price_ff == '0 && rsp_qty_ff == '0)
      else $error("empty result carries data");

   a_found_vol: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_found_ff |-> rsp_qty_ff != '0)
      else $error("found result with zero volume");

   a_book_cleared: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && state_in == ST_IDLE |=> buy_cnt_ff == '0 && sell_cnt_ff == '0
                                                   && !dropped_ff)
      else $error("book not cleared after uncross");

endmodule

>>> test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cau_pkg::*;

   localparam int PX_MAX = 32'h7FFF_FFFF;
   localparam int PX_MIN = int'(32'h8000_0000);

   typedef struct {
      logic             found;
      int               price;
      logic [VOL_W-1:0] volume;
      logic             overflow;
   } clear_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   int send_idle_pct;
   int rcv_idle_pct;
   int rcv_hold_cycles;
   int error_count;
   int items_sent;

   // book mirror
   int          bid_px[$];
   int unsigned bid_qty[$];
   int          ask_px[$];
   int unsigned ask_qty[$];
   bit          book_dropped;

   // running best candidate during an uncross
   bit              have_best;
   int              best_px;
   longint unsigned best_vol;
   longint unsigned best_surplus;
   pressure_type    best_pr;

   clear_result_type expected_clears[$];

   call_auction_uncross i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // receiver: random stalls, or a long hold-off when requested
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rcv_hold_cycles > 0) begin
            rsp_tready = 1'b0;
            rcv_hold_cycles--;
         end else begin
            rsp_tready = ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   function automatic void evaluate_price(int p, int ref_px);
      longint unsigned dem;
      longint unsigned sup;
      longint unsigned vol;
      longint unsigned sur;
      longint          d;
      longint          bd;
      pressure_type    pr;
      bit              take;
      dem = 0;
      sup = 0;
      foreach (bid_px[i]) begin
         if (bid_px[i] >= p) begin
            dem += bid_qty[i];
            if (dem > VOL_MAX) dem = VOL_MAX;
         end
      end
      foreach (ask_px[i]) begin
         if (ask_px[i] <= p) begin
            sup += ask_qty[i];
            if (sup > VOL_MAX) sup = VOL_MAX;
         end
      end
      vol = (dem < sup) ? dem : sup;
      if (vol == 0) return;
      sur = (dem > sup) ? dem - sup : sup - dem;
      pr = (dem == sup) ? PR_NONE : ((dem > sup) ? PR_BUY : PR_SELL);
      if (!have_best) take = 1'b1;
      else if (vol != best_vol) take = vol > best_vol;
      else if (sur != best_surplus) take = sur < best_surplus;
      else if (pr == best_pr && pr == PR_BUY) take = p > best_px;
      else if (pr == best_pr && pr == PR_SELL) take = p < best_px;
      else begin
         d  = longint'(p) - longint'(ref_px);
         bd = longint'(best_px) - longint'(ref_px);
         if (d < 0) d = -d;
         if (bd < 0) bd = -bd;
         take = (d != bd) ? (d < bd) : (p > best_px);
      end
      if (take) begin
         have_best    = 1'b1;
         best_px      = p;
         best_vol     = vol;
         best_surplus = sur;
         best_pr      = pr;
      end
   endfunction

   function automatic void predict_uncross(int ref_px);
      int               px[$];
      clear_result_type r;
      have_best    = 1'b0;
      best_px      = 0;
      best_vol     = 0;
      best_surplus = 0;
      best_pr      = PR_NONE;
      // bid prices high to low, then ask prices low to high, each price once
      px = bid_px;
      px.rsort();
      foreach (px[i]) if (i == 0 || px[i] != px[i-1]) evaluate_price(px[i], ref_px);
      px = ask_px;
      px.sort();
      foreach (px[i]) if (i == 0 || px[i] != px[i-1]) evaluate_price(px[i], ref_px);
      r.found    = have_best;
      r.price    = have_best ? best_px : 0;
      r.volume   = have_best ? best_vol[VOL_W-1:0] : '0;
      r.overflow = book_dropped;
      expected_clears.push_back(r);
      bid_px.delete();
      bid_qty.delete();
      ask_px.delete();
      ask_qty.delete();
      book_dropped = 1'b0;
   endfunction

   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      clear_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_clears.size() == 0) begin
            $display("%0t: unexpected result, expected none, got tdata %h tuser %h",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            exp_r = expected_clears.pop_front();
            check_field("found", exp_r.found, rsp_tuser[0]);
            check_field("overflow", exp_r.overflow, rsp_tuser[1]);
            check_field("clear_price", longint'(exp_r.price),
                        longint'($signed(rsp_tdata[PRICE_W-1:0])));
            check_field("matched_quantity", exp_r.volume,
                        rsp_tdata[PRICE_W +: VOL_W]);
         end
      end
   end

   // starts and ends at a falling edge
   task automatic send_item(cmd_type cmd, side_type side, int price, int unsigned qty,
                            int ref_px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = {side, cmd};
      req_tdata  = {ref_px, qty, price};
      do @(posedge clock); while (!req_tready);
      if (cmd == CMD_UNCROSS) predict_uncross(ref_px);
      else if (side == SIDE_BUY && bid_px.size() < MAX_LEVELS) begin
         bid_px.push_back(price);
         bid_qty.push_back(qty);
      end else if (side == SIDE_SELL && ask_px.size() < MAX_LEVELS) begin
         ask_px.push_back(price);
         ask_qty.push_back(qty);
      end else begin
         book_dropped = 1'b1;
      end
      items_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic load_level(side_type side, int price, int unsigned qty);
      send_item(CMD_LOAD, side, price, qty, int'($urandom));
   endtask

   task automatic uncross(int ref_px);
      send_item(CMD_UNCROSS, side_type'($urandom_range(1)), int'($urandom), $urandom, ref_px);
   endtask

   task automatic wait_drained();
      while (expected_clears.size() != 0) @(negedge clock);
   endtask

   function automatic int near_price(int center, int spread);
      longint v;
      v = longint'(center) + longint'($urandom_range(2 * spread)) - spread;
      if (v > PX_MAX) v = PX_MAX;
      if (v < PX_MIN) v = PX_MIN;
      return int'(v);
   endfunction

   function automatic int unsigned rand_qty();
      case ($urandom_range(7))
         0:       return 0;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom;
         default: return $urandom_range(1, 1000);
      endcase
   endfunction

   task automatic test_directed_cases();
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      uncross(0);
      // one side only
      load_level(SIDE_BUY, 100, 5);
      uncross(0);
      // price and quantity extremes, wide distance to reference
      load_level(SIDE_BUY, PX_MAX, 32'hFFFF_FFFF);
      load_level(SIDE_SELL, PX_MIN, 32'hFFFF_FFFF);
      uncross(PX_MIN);
      load_level(SIDE_BUY, PX_MAX, 32'hFFFF_FFFF);
      load_level(SIDE_SELL, PX_MIN, 32'hFFFF_FFFF);
      uncross(PX_MAX);
      // repeated prices and zero quantities
      load_level(SIDE_BUY, 10, 0);
      load_level(SIDE_BUY, 10, 7);
      load_level(SIDE_BUY, 12, 3);
      load_level(SIDE_SELL, 9, 4);
      load_level(SIDE_SELL, 11, 0);
      load_level(SIDE_SELL, 11, 6);
      uncross(11);
      // buy pressure on a flat tie: higher price wins
      load_level(SIDE_BUY, 30, 10);
      load_level(SIDE_SELL, 10, 4);
      load_level(SIDE_SELL, 20, 0);
      uncross(10);
      // sell pressure on a flat tie: lower price wins
      load_level(SIDE_SELL, -10, 10);
      load_level(SIDE_BUY, 30, 4);
      load_level(SIDE_BUY, 20, 0);
      uncross(30);
      // balanced: nearest to reference, then higher price
      load_level(SIDE_BUY, 30, 5);
      load_level(SIDE_SELL, 10, 5);
      uncross(12);
      load_level(SIDE_BUY, 30, 5);
      load_level(SIDE_SELL, 10, 5);
      uncross(20);
      wait_drained();
   endtask

   task automatic test_book_overflow();
      int k;
      int center;
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      center = int'($urandom);
      for (k = 0; k < MAX_LEVELS + 1; k++)
         load_level(SIDE_BUY, near_price(center, 200), rand_qty());
      for (k = 0; k < 3; k++) load_level(SIDE_SELL, near_price(center, 200), rand_qty());
      uncross(center);
      for (k = 0; k < MAX_LEVELS + 2; k++)
         load_level(SIDE_SELL, near_price(center, 200), rand_qty());
      for (k = 0; k < 2; k++) load_level(SIDE_BUY, near_price(center, 200), rand_qty());
      uncross(near_price(center, 50));
      // flag must be gone after the clear
      uncross(center);
      // both sides exactly full, no drop
      for (k = 0; k < MAX_LEVELS; k++) begin
         load_level(SIDE_BUY, near_price(center, 30), rand_qty());
         load_level(SIDE_SELL, near_price(center, 30), rand_qty());
      end
      uncross(center);
      wait_drained();
   endtask

   task automatic test_output_stall();
      int k;
      send_idle_pct   = 0;
      rcv_idle_pct    = 0;
      rcv_hold_cycles = 3000;
      repeat (4) begin
         for (k = 0; k < 5; k++)
            load_level(side_type'(k & 1), near_price(1000, 8), rand_qty());
         uncross(1000);
      end
      wait_drained();
   endtask

   task automatic test_random(int n_items, int send_pct, int rcv_pct);
      int start;
      int nb;
      int ns;
      int center;
      int spread;
      int kind;
      send_idle_pct = send_pct;
      rcv_idle_pct  = rcv_pct;
      start = items_sent;
      while (items_sent - start < n_items) begin
         kind = $urandom_range(99);
         if (kind < 6) begin
            if ($urandom_range(1)) uncross(int'($urandom));
            else load_level(side_type'($urandom_range(1)), int'($urandom), rand_qty());
         end else begin
            if (kind < 10) begin
               nb = $urandom_range(30, 70);
               ns = $urandom_range(0, 70);
            end else begin
               nb = $urandom_range(0, 10);
               ns = $urandom_range(0, 10);
            end
            case ($urandom_range(7))
               0:       center = PX_MAX;
               1:       center = PX_MIN;
               default: center = int'($urandom);
            endcase
            spread = $urandom_range(0, 40);
            while (nb + ns > 0) begin
               if (ns == 0 || (nb > 0 && $urandom_range(1))) begin
                  load_level(SIDE_BUY, near_price(center, spread), rand_qty());
                  nb--;
               end else begin
                  load_level(SIDE_SELL, near_price(center, spread), rand_qty());
                  ns--;
               end
            end
            uncross($urandom_range(1) ? near_price(center, spread + 10) : int'($urandom));
         end
      end
      wait_drained();
   endtask

   initial begin
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      req_tuser       = '0;
      send_idle_pct   = 0;
      rcv_idle_pct    = 0;
      rcv_hold_cycles = 0;
      error_count     = 0;
      items_sent      = 0;
      book_dropped    = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_cases();
      test_book_overflow();
      test_output_stall();
      test_random(75, 12, 60);
      test_random(75, 60, 12);
      test_random(75, 0, 0);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_clears.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
src/cau_pkg.sv
src/cau_level_mem.sv
src/call_auction_uncross.sv
test/tb_top.sv
